>>> rtl/core/rmq_pkg.sv
// Shared widths, branch codes and sideband types for the matrix to quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int W         = 16;                    // entry and result width
    localparam int SW        = W + 2;                 // trace and diagonal sums
    localparam int RS_W      = SW + 1;                // signed radicand before clamp
    localparam int RAD_W     = RS_W - 1;              // clamped radicand, positive
    localparam int SQ_IN_W   = RAD_W + FRAC_BITS - 2; // square root operand
    localparam int SQ_P      = (SQ_IN_W + 1) / 2;     // root bits, one per stage
    localparam int DW        = W + 1;                 // off-diagonal sum or difference
    localparam int NW        = DW + FRAC_BITS + 1;    // dividend, one quotient bit per stage
    localparam int DEN_W     = SQ_P + 2;              // divisor 4*root

    localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

    // Component that takes the square root
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_W = 2'd3;

    typedef struct packed {
        logic [1:0]           sel;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic                 clamped;
    } t_side;

    typedef struct packed {
        logic [1:0]      sel;
        logic [2:0]      neg;
        logic [SQ_P-1:0] root;
        logic            clamped;
    } t_dside;

endpackage

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RAD_W-1:0] i_rad,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [SQ_P-1:0]  o_root,
    output t_side            o_side
);

    localparam int REM_W = SQ_P + 3;
    localparam int X_W   = 2 * SQ_P;

    logic             r_vld  [SQ_P];
    logic [REM_W-1:0] r_rem  [SQ_P];
    logic [SQ_P-1:0]  r_root [SQ_P];
    logic [X_W-1:0]   r_x    [SQ_P];
    t_side            r_side [SQ_P];

    logic [REM_W-1:0] n_rem  [SQ_P];
    logic [SQ_P-1:0]  n_root [SQ_P];
    logic [X_W-1:0]   n_x    [SQ_P];

    // One trial subtraction per stage
    always_comb begin
        logic [REM_W-1:0] rem_in;
        logic [SQ_P-1:0]  root_in;
        logic [X_W-1:0]   x_in;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < SQ_P; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                x_in    = X_W'({i_rad, {(FRAC_BITS-2){1'b0}}});
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                x_in    = r_x[k-1];
            end
            rem2  = {rem_in[REM_W-3:0], x_in[X_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            if (rem2 >= trial) begin
                n_rem[k]  = rem2 - trial;
                n_root[k] = {root_in[SQ_P-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2;
                n_root[k] = {root_in[SQ_P-2:0], 1'b0};
            end
            n_x[k] = {x_in[X_W-3:0], 2'b00};
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_P; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < SQ_P; k++) r_vld[k] <= (k == 0) ? i_vld : r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_P; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= n_x[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[SQ_P-1];
    assign o_root = r_root[SQ_P-1];
    assign o_side = r_side[SQ_P-1];

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_root != '0))
        else $error("root of a clamped radicand must be nonzero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (o_vld == $past(o_vld)) && (o_root == $past(o_root)))
        else $error("sqrt pipeline moved while held");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_vld) |=> r_vld[0])
        else $error("sqrt first stage lost a word");

endmodule

>>> rtl/core/rmq_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, with sideband.
module rmq_div
    import rmq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NW-1:0]    i_num [3],
    input  logic [DEN_W-1:0] i_den,
    input  t_dside           i_side,
    output logic             o_vld,
    output logic [NW-1:0]    o_q   [3],
    output t_dside           o_side
);

    // Dividend bits leave at the top while quotient bits enter at the bottom
    logic             r_vld  [NW];
    logic [NW-1:0]    r_n    [NW][3];
    logic [DEN_W-1:0] r_rem  [NW][3];
    logic [DEN_W-1:0] r_den  [NW];
    t_dside           r_side [NW];

    logic [NW-1:0]    n_n    [NW][3];
    logic [DEN_W-1:0] n_rem  [NW][3];

    always_comb begin
        logic [NW-1:0]    n_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   rem2;
        for (int k = 0; k < NW; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    n_in   = i_num[l];
                    rem_in = '0;
                    den_in = i_den;
                end else begin
                    n_in   = r_n[k-1][l];
                    rem_in = r_rem[k-1][l];
                    den_in = r_den[k-1];
                end
                rem2 = {rem_in, n_in[NW-1]};
                if (rem2 >= {1'b0, den_in}) begin
                    n_rem[k][l] = DEN_W'(rem2 - {1'b0, den_in});
                    n_n[k][l]   = {n_in[NW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = rem2[DEN_W-1:0];
                    n_n[k][l]   = {n_in[NW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= (k == 0) ? i_vld : r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_n[k][l]   <= n_n[k][l];
                    r_rem[k][l] <= n_rem[k][l];
                end
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_q[0] = r_n[NW-1][0];
    assign o_q[1] = r_n[NW-1][1];
    assign o_q[2] = r_n[NW-1][2];
    assign o_side = r_side[NW-1];

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld && i_en |-> (i_den != '0))
        else $error("divider fed a zero divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (o_vld == $past(o_vld)) && (o_side == $past(o_side)))
        else $error("divider pipeline moved while held");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_vld) |=> r_vld[0])
        else $error("divider first stage lost a word");

endmodule

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix in, unit quaternion out, fully pipelined.
//
//  channel  direction  handshake           payload
//  matrix   in         i_valid / o_stall   i_right_*, i_up_*, i_at_* (Q2.14)
//  quat     out        o_valid / i_stall   o_quat_x/y/z/w (Q2.14), o_radicand_clamped
//
// One word enters per cycle unless o_stall is high. At Q2.14 the pipeline holds, in order:
// one stage for trace and branch select, a 15-stage square root, a setup stage,
// a 32-stage divider (three lanes side by side) and the output register.
// A stall on the output while a word waits there holds every stage at once; o_stall follows it.
// Reset clears the valid bits only.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [W-1:0] i_right_x,
    input  logic signed [W-1:0] i_right_y,
    input  logic signed [W-1:0] i_right_z,
    input  logic signed [W-1:0] i_up_x,
    input  logic signed [W-1:0] i_up_y,
    input  logic signed [W-1:0] i_up_z,
    input  logic signed [W-1:0] i_at_x,
    input  logic signed [W-1:0] i_at_y,
    input  logic signed [W-1:0] i_at_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [W-1:0] o_quat_x,
    output logic signed [W-1:0] o_quat_y,
    output logic signed [W-1:0] o_quat_z,
    output logic signed [W-1:0] o_quat_w,
    output logic                o_radicand_clamped
);

    logic en;
    logic r_out_vld;

    // Hold the whole pipe while the output word waits
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // Stage A: trace, branch, radicand and off-diagonal terms
    logic             r_a_vld;
    logic [RAD_W-1:0] r_a_rad;
    t_side            r_a_side;
    logic [RAD_W-1:0] n_a_rad;
    t_side            n_a_side;

    always_comb begin
        logic signed [SW-1:0]   rx, ry, rz, ux, uy, uz, ax, ay, az;
        logic signed [SW-1:0]   t, b, c, e;
        logic signed [RS_W-1:0] rs;
        rx = SW'(i_right_x); ry = SW'(i_right_y); rz = SW'(i_right_z);
        ux = SW'(i_up_x);    uy = SW'(i_up_y);    uz = SW'(i_up_z);
        ax = SW'(i_at_x);    ay = SW'(i_at_y);    az = SW'(i_at_z);
        t = uy + rx + az;
        b = rx - uy - az;
        c = uy - rx - az;
        e = az - uy - rx;
        n_a_side = '0;
        priority if (!t[SW-1]) begin
            n_a_side.sel = SEL_W;
            rs = RS_W'(t);
            n_a_side.d0 = DW'(uz - ay);
            n_a_side.d1 = DW'(ax - rz);
            n_a_side.d2 = DW'(ry - ux);
        end else if (!b[SW-1]) begin
            n_a_side.sel = SEL_X;
            rs = RS_W'(b);
            n_a_side.d0 = DW'(ux + ry);
            n_a_side.d1 = DW'(ax + rz);
            n_a_side.d2 = DW'(uz - ay);
        end else if (!c[SW-1]) begin
            n_a_side.sel = SEL_Y;
            rs = RS_W'(c);
            n_a_side.d0 = DW'(ux + ry);
            n_a_side.d1 = DW'(ay + uz);
            n_a_side.d2 = DW'(ax - rz);
        end else begin
            n_a_side.sel = SEL_Z;
            rs = RS_W'(e);
            n_a_side.d0 = DW'(ax + rz);
            n_a_side.d1 = DW'(ay + uz);
            n_a_side.d2 = DW'(ry - ux);
        end
        rs = rs + RS_W'(1 << FRAC_BITS);
        // Clamp a radicand at or below zero to one LSB
        if (rs <= 0) begin
            n_a_rad          = RAD_W'(1);
            n_a_side.clamped = 1'b1;
        end else begin
            n_a_rad          = rs[RAD_W-1:0];
            n_a_side.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rad  <= n_a_rad;
            r_a_side <= n_a_side;
        end
    end

    // Square root: main component M
    logic            sq_vld;
    logic [SQ_P-1:0] sq_root;
    t_side           sq_side;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_a_vld),
        .i_rad   (r_a_rad),
        .i_side  (r_a_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage B: magnitudes, rounded dividends and divisor 4*M
    logic             r_b_vld;
    logic [NW-1:0]    r_b_num [3];
    logic [DEN_W-1:0] r_b_den;
    t_dside           r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [DW-1:0] d [3];
        logic [DW-1:0]        mag;
        if (en) begin
            d[0] = sq_side.d0;
            d[1] = sq_side.d1;
            d[2] = sq_side.d2;
            for (int l = 0; l < 3; l++) begin
                mag = d[l][DW-1] ? DW'(-d[l]) : DW'(d[l]);
                r_b_num[l]     <= (NW'(mag) << FRAC_BITS) + (NW'(sq_root) << 1);
                r_b_side.neg[l] <= d[l][DW-1];
            end
            r_b_den          <= DEN_W'(sq_root) << 2;
            r_b_side.sel     <= sq_side.sel;
            r_b_side.root    <= sq_root;
            r_b_side.clamped <= sq_side.clamped;
        end
    end

    // Division of the three off-diagonal terms
    logic          dv_vld;
    logic [NW-1:0] dv_q [3];
    t_dside        dv_side;

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_b_vld),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_side  (r_b_side),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // Saturate and place each lane at its component
    logic signed [W-1:0] r_q [4];
    logic                r_clamped;
    logic signed [W-1:0] n_q [4];

    always_comb begin
        logic signed [W-1:0] lane [3];
        logic signed [W-1:0] main_c;
        int                  k;
        for (int l = 0; l < 3; l++) begin
            if (dv_side.neg[l]) begin
                lane[l] = (dv_q[l] > NW'(1 << (W-1))) ? Q_MIN : W'(-dv_q[l]);
            end else begin
                lane[l] = (dv_q[l] > NW'(Q_MAX)) ? Q_MAX : W'(dv_q[l]);
            end
        end
        main_c = (dv_side.root > SQ_P'(Q_MAX)) ? Q_MAX : W'(dv_side.root);
        for (int i = 0; i < 4; i++) begin
            k = (i < int'(dv_side.sel)) ? i : i - 1;
            if (i == int'(dv_side.sel)) begin
                n_q[i] = main_c;
            end else begin
                n_q[i] = lane[k[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) r_q[i] <= n_q[i];
            r_clamped <= dv_side.clamped;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_quat_x           = r_q[0];
    assign o_quat_y           = r_q[1];
    assign o_quat_z           = r_q[2];
    assign o_quat_w           = r_q[3];
    assign o_radicand_clamped = r_clamped;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no word waiting at the output");

    a_stage_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_a_vld)
        else $error("accepted word missing from first stage");

    a_main_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld |-> (dv_side.root != '0))
        else $error("main component reached output stage as zero");

endmodule
